// File: hdl/jse_pkg.sv
// jse_pkg: shared types and constants for the JSON string escaper.
// Holds the queue entry type, status codes and byte constants.
// No dependencies; every other file in hdl imports it.
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    localparam int CMP_WIDTH   = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 2;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] LIMIT_RESET = 16'd2048;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BADCHAR  = 2'd2;

    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;

    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_QUOTE  = 8'h22;
    localparam logic [7:0] BYTE_SLASH  = 8'h2F;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_LC_N   = 8'h6E;
    localparam logic [7:0] BYTE_LC_T   = 8'h74;
    localparam logic [7:0] CTRL_MAX    = 8'h1F;
    localparam logic [7:0] ASCII_MAX   = 8'h7F;

    localparam logic [7:0] MASK_C0 = 8'hC0;
    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] PAT_CONT  = 8'h80;
    localparam logic [7:0] PAT_LEAD2 = 8'hC0;
    localparam logic [7:0] PAT_LEAD3 = 8'hE0;
    localparam logic [7:0] PAT_LEAD4 = 8'hF0;

    // One queue entry: up to four output bytes (byte i at bits 8i+7:8i),
    // index of the last byte, and the end-of-string flag with its status.
    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  last;
        logic        eos;
        logic [1:0]  status;
    } t_entry;

endpackage
`default_nettype wire

// File: hdl/json_string_escaper_unit.sv
// json_string_escaper_unit: top level of the streaming JSON string escaper.
// Instantiates jse_front, jse_queue and jse_back; holds the APB register.
// Depends on jse_pkg.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_byte): one raw string byte
//    per transfer; byte 0 ends a string.
//  - Output channel (o_out_valid / i_out_stall / o_out_byte, o_end_of_string,
//    o_status): one escaped byte per transfer. The end item of a string has
//    o_end_of_string high, o_out_byte zero and the string's status.
//  - APB port: register 0 at byte address 0 is output_limit (16 bits, reset
//    2048). Write it only while the block is idle.
//  - Path: the first byte produced by an input transfer is written to the queue,
//    then loaded into the output register; then one byte per cycle, stall aside.
//  - Throughput: the output register drains one byte per cycle while the
//    receiver does not stall; an input byte produces zero to four output bytes
//    (two for an escape). The front takes a byte every cycle until the four-entry
//    queue fills; the queue depth sets how far it can run ahead.
//  - Reset (synchronous, active low) clears string state, the queue and the
//    output register, and restores output_limit to 2048.
//  - Receiver stall: the output register holds its byte; the queue fills,
//    and once full, o_in_stall rises and input transfers stop.
`timescale 1ns / 1ps
`default_nettype none
module json_string_escaper_unit import jse_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_end_of_string,
    output logic [1:0]       o_status,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [LIMIT_WIDTH-1:0] r_limit;
    logic   w_accept;
    logic   w_push;
    t_entry w_entry;
    logic   w_pop;
    t_entry w_head;
    logic   w_empty;
    logic   w_full;

    // Config register: write on the access phase, read back with zero fill.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? {16'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_LIMIT) begin
            r_limit <= pwdata[LIMIT_WIDTH-1:0];
        end
    end

    // Hold off the sender only when the queue has no room for a new entry.
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    jse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in_byte),
        .i_limit   (r_limit),
        .o_push    (w_push),
        .o_entry   (w_entry)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    jse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

// File: hdl/jse_front.sv
// jse_front: accepts input bytes, tracks string state and UTF-8 sequences,
// and turns each byte into at most one queue entry.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jse_front import jse_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_in_byte,
    input  wire logic [LIMIT_WIDTH-1:0] i_limit,
    output logic                        o_push,
    output t_entry                      o_entry
);

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [23:0]            r_held, n_held;
    logic [2:0]             r_seq, n_seq;
    logic [1:0]             r_held_cnt, n_held_cnt;
    logic                   r_discard, n_discard;

    logic [CMP_WIDTH-1:0] w_count_x, w_limit_x;
    logic [2:0]           w_seq_m1;

    function automatic logic [31:0] place_byte(input logic [7:0] b, input logic [1:0] pos);
        logic [31:0] v;
        v = 32'd0;
        case (pos)
            2'd0: v[7:0]   = b;
            2'd1: v[15:8]  = b;
            2'd2: v[23:16] = b;
            2'd3: v[31:24] = b;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    assign w_count_x = CMP_WIDTH'(r_count);
    assign w_limit_x = CMP_WIDTH'(i_limit);
    assign w_seq_m1  = r_seq - 3'd1;

    always_comb begin
        n_count    = r_count;
        n_held     = r_held;
        n_seq      = r_seq;
        n_held_cnt = r_held_cnt;
        n_discard  = r_discard;
        o_push     = 1'b0;
        o_entry    = '{data: 32'd0, last: 2'd0, eos: 1'b0, status: ST_OK};

        if (i_accept) begin
            if (r_discard) begin
                if (i_in_byte == BYTE_NUL) begin
                    n_discard  = 1'b0;
                    n_count    = '0;
                    n_held     = '0;
                    n_seq      = '0;
                    n_held_cnt = '0;
                end
            end else if (r_seq != 3'd0) begin
                if (i_in_byte == BYTE_NUL) begin
                    // terminator inside a sequence: end the string, no discard
                    o_push         = 1'b1;
                    o_entry.eos    = 1'b1;
                    o_entry.status = ST_BADCHAR;
                    n_count        = '0;
                    n_held         = '0;
                    n_seq          = '0;
                    n_held_cnt     = '0;
                end else if ((i_in_byte & MASK_C0) != PAT_CONT) begin
                    o_push         = 1'b1;
                    o_entry.eos    = 1'b1;
                    o_entry.status = ST_BADCHAR;
                    n_discard      = 1'b1;
                    n_count        = '0;
                    n_held         = '0;
                    n_seq          = '0;
                    n_held_cnt     = '0;
                end else if ({1'b0, r_held_cnt} + 3'd1 < r_seq) begin
                    n_held     = 24'({8'd0, r_held} | place_byte(i_in_byte, r_held_cnt));
                    n_held_cnt = r_held_cnt + 2'd1;
                end else if (w_count_x + CMP_WIDTH'(r_seq) + CMP_WIDTH'(1) > w_limit_x) begin
                    // complete sequence without room
                    o_push         = 1'b1;
                    o_entry.eos    = 1'b1;
                    o_entry.status = ST_BADCHAR;
                    n_discard      = 1'b1;
                    n_count        = '0;
                    n_held         = '0;
                    n_seq          = '0;
                    n_held_cnt     = '0;
                end else begin
                    o_push       = 1'b1;
                    o_entry.data = {8'd0, r_held} | place_byte(i_in_byte, w_seq_m1[1:0]);
                    o_entry.last = w_seq_m1[1:0];
                    n_count      = r_count + COUNT_WIDTH'(r_seq);
                    n_held       = '0;
                    n_seq        = '0;
                    n_held_cnt   = '0;
                end
            end else if (i_in_byte == BYTE_NUL) begin
                o_push         = 1'b1;
                o_entry.eos    = 1'b1;
                o_entry.status = ST_OK;
                n_count        = '0;
                n_held         = '0;
                n_seq          = '0;
                n_held_cnt     = '0;
            end else if (w_count_x + CMP_WIDTH'(1) >= w_limit_x) begin
                o_push         = 1'b1;
                o_entry.eos    = 1'b1;
                o_entry.status = ST_OVERFLOW;
                n_discard      = 1'b1;
                n_count        = '0;
            end else if (i_in_byte == BYTE_QUOTE || i_in_byte == BYTE_BSLASH ||
                         i_in_byte == BYTE_SLASH || i_in_byte == BYTE_TAB ||
                         i_in_byte == BYTE_LF) begin
                if (w_count_x + CMP_WIDTH'(3) > w_limit_x) begin
                    o_push         = 1'b1;
                    o_entry.eos    = 1'b1;
                    o_entry.status = ST_OVERFLOW;
                    n_discard      = 1'b1;
                    n_count        = '0;
                end else begin
                    o_push            = 1'b1;
                    o_entry.data[7:0] = BYTE_BSLASH;
                    o_entry.data[15:8] = (i_in_byte == BYTE_LF)  ? BYTE_LC_N :
                                         (i_in_byte == BYTE_TAB) ? BYTE_LC_T : i_in_byte;
                    o_entry.last      = 2'd1;
                    n_count           = r_count + COUNT_WIDTH'(2);
                end
            end else if (i_in_byte <= CTRL_MAX) begin
                o_push         = 1'b1;
                o_entry.eos    = 1'b1;
                o_entry.status = ST_BADCHAR;
                n_discard      = 1'b1;
                n_count        = '0;
            end else if (i_in_byte <= ASCII_MAX) begin
                o_push            = 1'b1;
                o_entry.data[7:0] = i_in_byte;
                n_count           = r_count + COUNT_WIDTH'(1);
            end else if ((i_in_byte & MASK_E0) == PAT_LEAD2) begin
                n_seq      = 3'd2;
                n_held     = {16'd0, i_in_byte};
                n_held_cnt = 2'd1;
            end else if ((i_in_byte & MASK_F0) == PAT_LEAD3) begin
                n_seq      = 3'd3;
                n_held     = {16'd0, i_in_byte};
                n_held_cnt = 2'd1;
            end else if ((i_in_byte & MASK_F8) == PAT_LEAD4) begin
                n_seq      = 3'd4;
                n_held     = {16'd0, i_in_byte};
                n_held_cnt = 2'd1;
            end else begin
                o_push         = 1'b1;
                o_entry.eos    = 1'b1;
                o_entry.status = ST_BADCHAR;
                n_discard      = 1'b1;
                n_count        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_held     <= '0;
            r_seq      <= '0;
            r_held_cnt <= '0;
            r_discard  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_held     <= n_held;
            r_seq      <= n_seq;
            r_held_cnt <= n_held_cnt;
            r_discard  <= n_discard;
        end
    end

endmodule
`default_nettype wire

// File: hdl/jse_queue.sv
// jse_queue: short flip-flop queue of entries between front and back.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jse_queue import jse_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output logic        o_empty,
    output logic        o_full
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCOUNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCOUNT_W'(1);
                2'b01:   r_count <= r_count - QCOUNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/jse_back.sv
// jse_back: walks the bytes of the head queue entry into the output register,
// one byte per cycle, honoring the receiver's stall.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jse_back import jse_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_head,
    input  wire logic   i_empty,
    output logic        o_pop,
    input  wire logic   i_out_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_string,
    output logic [1:0]  o_status
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eos;
    logic [1:0] r_status;
    logic       w_load;
    logic [7:0] w_sel;

    assign w_load = !r_valid || !i_out_stall;
    assign o_pop  = w_load && !i_empty && (r_idx == i_head.last);

    always_comb begin
        case (r_idx)
            2'd0:    w_sel = i_head.data[7:0];
            2'd1:    w_sel = i_head.data[15:8];
            2'd2:    w_sel = i_head.data[23:16];
            2'd3:    w_sel = i_head.data[31:24];
            default: w_sel = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= (r_idx == i_head.last) ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_byte   <= w_sel;
            r_eos    <= i_head.eos;
            r_status <= i_head.status;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_end_of_string = r_eos;
    assign o_status        = r_status;

endmodule
`default_nettype wire
